/* design/cspm_pkg.sv */
// ----------------------------------------------------------------------------
// cspm_pkg: shared types and codes for the sparse MTTKRP block
// Payload structs, action and register codes, controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package cspm_pkg;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_NZ    = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_MODES  = 2'd1;

  typedef struct packed {
    logic [1:0]         action;
    logic [1:0]         factor_sel;
    logic [9:0]         row;
    logic [3:0]         column;
    logic signed [31:0] value;
    logic [9:0]         idx_first;
    logic [9:0]         idx_second;
    logic [9:0]         idx_third;
    logic [9:0]         idx_fourth;
  } in_t;

  typedef struct packed {
    logic signed [47:0] read_data;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic load_wr;
    logic capture;
    logic clr_start;
    logic clr_step;
    logic f_read;
    logic mul;
    logic scale;
    logic r_read;
    logic r_write;
    logic rd_start;
  } cmd_t;

  typedef struct packed {
    logic load_ok;
    logic nz_ok;
    logic clr_last;
    logic mode_last;
    logic col_last;
  } status_t;

endpackage

`default_nettype wire

/* design/cspm_ctrl.sv */
// ----------------------------------------------------------------------------
// cspm_ctrl: sequencer for the sparse MTTKRP block
// Walks columns and modes of a nonzero, the clearing sweep and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module cspm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       action,
  input  wire cspm_pkg::status_t status,
  output logic                  busy,
  output logic                  done,
  output cspm_pkg::cmd_t        cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_CLEAR  = 8'b0000_0010,
    S_FREAD  = 8'b0000_0100,
    S_FMUL   = 8'b0000_1000,
    S_FSCALE = 8'b0001_0000,
    S_RREAD  = 8'b0010_0000,
    S_RWRITE = 8'b0100_0000,
    S_ROUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (action)
            cspm_pkg::ACT_LOAD: begin
              cmd.load_wr = status.load_ok;
            end
            cspm_pkg::ACT_NZ: begin
              if (status.nz_ok) begin
                cmd.capture = 1'b1;
                state_next  = S_FREAD;
              end
            end
            cspm_pkg::ACT_READ: begin
              cmd.rd_start = 1'b1;
              cmd.r_read   = 1'b1;
              state_next   = S_ROUT;
            end
            default: begin
              cmd.clr_start = 1'b1;
              state_next    = S_CLEAR;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) state_next = S_IDLE;
      end
      S_FREAD: begin
        cmd.f_read = 1'b1;
        state_next = S_FMUL;
      end
      S_FMUL: begin
        cmd.mul    = 1'b1;
        state_next = S_FSCALE;
      end
      S_FSCALE: begin
        cmd.scale  = 1'b1;
        state_next = status.mode_last ? S_RREAD : S_FREAD;
      end
      S_RREAD: begin
        cmd.r_read = 1'b1;
        state_next = S_RWRITE;
      end
      S_RWRITE: begin
        cmd.r_write = 1'b1;
        state_next  = status.col_last ? S_IDLE : S_FREAD;
      end
      S_ROUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_ROUT);

endmodule

`default_nettype wire

/* design/cspm_dp.sv */
// ----------------------------------------------------------------------------
// cspm_dp: datapath of the sparse MTTKRP block
// Factor and result memories, multiplier, accumulator and config registers.
// ----------------------------------------------------------------------------
`default_nettype none

module cspm_dp #(
  parameter int RANK      = 16,
  parameter int ROWS      = 1024,
  parameter int MAX_MODES = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cspm_pkg::in_t     item,
  input  wire cspm_pkg::cmd_t    cmd,
  input  wire logic              wr_en,
  input  wire logic [1:0]        wr_index,
  input  wire logic [2:0]        wr_data,
  output cspm_pkg::status_t      status,
  output cspm_pkg::out_t         result
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = (RANK > 1) ? $clog2(RANK) : 1;
  localparam int XW = (RW > 10) ? RW : 10;
  localparam int KW = (CW > 4) ? CW : 4;
  localparam int FAW = 2 + RW + CW;
  localparam int RAW = RW + CW;

  logic [1:0]         tgt;
  logic [2:0]         mcnt;
  logic [2:0]         modes;
  logic signed [31:0] val;
  logic [3:0][9:0]    idx;
  logic [CW-1:0]      k;
  logic [1:0]         m;
  logic signed [31:0] acc;
  logic signed [31:0] fdata;
  logic signed [63:0] prod;
  logic [47:0]        rdata;
  logic               sat;
  logic               rd_ok;
  logic [RAW-1:0]     clr_addr;

  logic signed [31:0] fmem [2**FAW];
  logic [47:0]        rmem [2**RAW];

  logic [3:0][9:0]    idx_in;
  logic [1:0]         first_mode;
  logic [2:0]         nxt;
  logic [XW-1:0]      row_x, coord_x, trow_x;
  logic [KW-1:0]      col_x;
  logic [RW-1:0]      row_a, coord_a, trow_a;
  logic [CW-1:0]      col_a;
  logic               nz_ok;
  logic signed [47:0] q;
  logic signed [31:0] q_sat;
  logic signed [48:0] sum;
  logic [47:0]        sum_sat;
  logic               sum_ovf;
  logic [RAW-1:0]     raddr;

  always_comb begin
    if (mcnt < 3'd3)                     modes = 3'd3;
    else if (mcnt > 3'(MAX_MODES))       modes = 3'(MAX_MODES);
    else                                 modes = mcnt;
  end

  assign idx_in = {item.idx_fourth, item.idx_third, item.idx_second, item.idx_first};

  always_comb begin
    nz_ok = ({1'b0, tgt} < modes);
    for (int i = 0; i < 4; i++) begin
      if ((3'(i) < modes) && (32'(idx_in[i]) >= ROWS)) nz_ok = 1'b0;
    end
  end

  assign row_x   = XW'(item.row);
  assign row_a   = row_x[RW-1:0];
  assign col_x   = KW'(item.column);
  assign col_a   = col_x[CW-1:0];
  assign coord_x = XW'(idx[m]);
  assign coord_a = coord_x[RW-1:0];
  assign trow_x  = XW'(idx[tgt]);
  assign trow_a  = trow_x[RW-1:0];

  assign first_mode = (tgt == 2'd0) ? 2'd1 : 2'd0;

  // step past the target mode
  always_comb begin
    nxt = {1'b0, m} + 3'd1;
    if (nxt == {1'b0, tgt}) nxt = nxt + 3'd1;
  end

  // floor shift of the product, then clamp to 32 bits
  assign q = prod[63:16];
  always_comb begin
    if ((q[47:31] != {17{1'b0}}) && (q[47:31] != {17{1'b1}})) begin
      q_sat = q[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      q_sat = q[31:0];
    end
  end

  assign sum     = {rdata[47], rdata} + {{17{acc[31]}}, acc};
  assign sum_ovf = (sum[48] != sum[47]);
  assign sum_sat = sum_ovf ? (sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}}) : sum[47:0];

  assign raddr = cmd.rd_start ? {row_a, col_a} : {trow_a, k};

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt      <= 2'd0;
      mcnt     <= 3'd3;
      sat      <= 1'b0;
      clr_addr <= '0;
    end else begin
      if (wr_en && (wr_index == cspm_pkg::REG_TARGET)) tgt  <= wr_data[1:0];
      if (wr_en && (wr_index == cspm_pkg::REG_MODES))  mcnt <= wr_data;
      if (cmd.clr_start) begin
        sat      <= 1'b0;
        clr_addr <= '0;
      end else if (cmd.clr_step) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (cmd.r_write && sum_ovf) sat <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      val <= item.value;
      idx <= idx_in;
      k   <= '0;
      m   <= first_mode;
      acc <= item.value;
    end else if (cmd.scale) begin
      acc <= q_sat;
      m   <= nxt[1:0];
    end else if (cmd.r_write) begin
      k   <= k + 1'b1;
      m   <= first_mode;
      acc <= val;
    end
    if (cmd.mul) prod <= acc * fdata;
    if (cmd.rd_start) rd_ok <= (32'(item.row) < ROWS) && (32'(item.column) < RANK);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) fmem[{item.factor_sel, row_a, col_a}] <= item.value;
    if (cmd.f_read)  fdata <= fmem[{m, coord_a, k}];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step)     rmem[clr_addr] <= '0;
    else if (cmd.r_write) rmem[{trow_a, k}] <= sum_sat;
    if (cmd.r_read)       rdata <= rmem[raddr];
  end

  assign status.load_ok   = (32'(item.factor_sel) < MAX_MODES) && (32'(item.row) < ROWS)
                            && (32'(item.column) < RANK);
  assign status.nz_ok     = nz_ok;
  assign status.clr_last  = (clr_addr == {RAW{1'b1}});
  assign status.mode_last = (nxt >= modes);
  assign status.col_last  = (k == CW'(RANK - 1));

  assign result.read_data = rd_ok ? rdata : 48'sd0;
  assign result.saturated = sat;

endmodule

`default_nettype wire

/* design/coo_sparse_mttkrp.sv */
// ----------------------------------------------------------------------------
// coo_sparse_mttkrp: sparse tensor MTTKRP in coordinate form
// Channel   Signals                       Transfer
// command   start, busy, cmd              start high and busy low at a clock edge
// result    done, result                  done high for one cycle, always taken
// config    wr_en, wr_index, wr_data      wr_en high at a clock edge
// Load leaves busy low; read shows its result in the cycle after, busy high.
// Nonzero: per column, a factor read, multiply and scale on the shared multiplier
// for each non-target mode, then the result entry is read, then written.
// Reset and clear sweep the result memory, one entry a cycle, with busy high.
// Results cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module coo_sparse_mttkrp #(
  parameter int RANK      = 16,
  parameter int ROWS      = 1024,
  parameter int MAX_MODES = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire cspm_pkg::in_t    cmd,
  output logic                  done,
  output cspm_pkg::out_t        result,
  input  wire logic             wr_en,
  input  wire logic [1:0]       wr_index,
  input  wire logic [2:0]       wr_data
);

  cspm_pkg::cmd_t    dp_cmd;
  cspm_pkg::status_t dp_status;

  cspm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (cmd.action),
    .status (dp_status),
    .busy   (busy),
    .done   (done),
    .cmd    (dp_cmd)
  );

  cspm_dp #(
    .RANK      (RANK),
    .ROWS      (ROWS),
    .MAX_MODES (MAX_MODES)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .item     (cmd),
    .cmd      (dp_cmd),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .status   (dp_status),
    .result   (result)
  );

  a_done_after_read: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (cmd.action == cspm_pkg::ACT_READ)))
    else $error("result strobe without a read transfer");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.action == cspm_pkg::ACT_READ ||
      cmd.action == cspm_pkg::ACT_CLEAR)) |=> busy)
    else $error("block idle after read or clear transfer");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

`default_nettype wire

/* dv/tb_coo_sparse_mttkrp.sv */
// ----------------------------------------------------------------------------
// tb_coo_sparse_mttkrp: self-checking bench for the sparse MTTKRP block
// Preloads the factor rows that nonzeros touch, then runs directed and random
// load / nonzero / read / clear commands under several mode settings. A
// scoreboard predicts every read and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_coo_sparse_mttkrp;

  localparam int NRANK = 16;
  localparam int NROWS = 1024;
  localparam int WDOG_LIMIT = 60000;
  localparam int IN_W = $bits(cspm_pkg::in_t);

  class mttkrp_sb;
    logic signed [31:0] factor[4][NROWS][NRANK];
    longint accum[NROWS][NRANK];
    bit sat;
    int tgt;
    int modes;
    cspm_pkg::out_t pending[$];
    int errors;

    function new();
      foreach (factor[m, r, k]) factor[m][r][k] = '0;
      clear_results();
      tgt = 0;
      modes = 3;
      errors = 0;
    endfunction

    function void clear_results();
      foreach (accum[r, k]) accum[r][k] = 0;
      sat = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [2:0] data);
      if (idx == cspm_pkg::REG_TARGET) tgt = int'(data[1:0]);
      else if (idx == cspm_pkg::REG_MODES) modes = int'(data);
    endfunction

    // Q16.16 product: floor shift, then clamp to 32 bits
    function logic signed [31:0] qmul(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      p = p >>> 16;
      if (p > 64'sh7fffffff) return 32'sh7fffffff;
      if (p < -64'sh80000000) return 32'sh80000000;
      return p[31:0];
    endfunction

    function void note_cmd(cspm_pkg::in_t c);
      int md;
      int co[4];
      logic signed [31:0] a;
      longint s;
      cspm_pkg::out_t o;
      case (c.action)
        cspm_pkg::ACT_LOAD: factor[c.factor_sel][c.row][c.column] = c.value;
        cspm_pkg::ACT_NZ: begin
          md = modes < 3 ? 3 : (modes > 4 ? 4 : modes);
          if (tgt >= md) return;
          co[0] = int'(c.idx_first);
          co[1] = int'(c.idx_second);
          co[2] = int'(c.idx_third);
          co[3] = int'(c.idx_fourth);
          for (int k = 0; k < NRANK; k++) begin
            a = c.value;
            for (int m = 0; m < md; m++)
              if (m != tgt) a = qmul(a, factor[m][co[m]][k]);
            s = accum[co[tgt]][k] + longint'(a);
            if (s > 64'sh7fff_ffff_ffff) begin
              s = 64'sh7fff_ffff_ffff;
              sat = 1;
            end else if (s < -64'sh8000_0000_0000) begin
              s = -64'sh8000_0000_0000;
              sat = 1;
            end
            accum[co[tgt]][k] = s;
          end
        end
        cspm_pkg::ACT_READ: begin
          o.read_data = accum[c.row][c.column][47:0];
          o.saturated = sat;
          pending.push_back(o);
        end
        default: clear_results();
      endcase
    endfunction

    function void check(cspm_pkg::out_t r);
      cspm_pkg::out_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %h", r);
        return;
      end
      e = pending.pop_front();
      if (r.read_data !== e.read_data || r.saturated !== e.saturated) begin
        errors++;
        if (errors <= 10)
          $display("read mismatch: exp data %h sat %b, got data %h sat %b",
                   e.read_data, e.saturated, r.read_data, r.saturated);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  cspm_pkg::in_t cmd = '0;
  logic done;
  cspm_pkg::out_t result;
  logic wr_en = 0;
  logic [1:0] wr_index = '0;
  logic [2:0] wr_data = '0;

  mttkrp_sb sb = new();
  int wdog = 0;
  bit quiet = 0;
  int hot_rows[$] = '{0, 1, 2, 1023};
  int touched[$];

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  coo_sparse_mttkrp dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always @(posedge clk) begin
    if (!rst && done) sb.check(result);
    if (rst || done || wr_en || (start && !busy)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic issue(cspm_pkg::in_t c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start = 0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    start = 1;
    cmd = c;
    do @(posedge clk); while (busy);
    sb.note_cmd(c);
    @(negedge clk);
    start = 0;
  endtask

  task automatic wait_idle();
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] idx, logic [2:0] data);
    wr_en = 1;
    wr_index = idx;
    wr_data = data;
    @(negedge clk);
    wr_en = 0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic signed [31:0] rand_q();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return 32'sh10000 + $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
      default: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
    endcase
  endfunction

  // random filler for the fields an action does not use
  function automatic cspm_pkg::in_t rand_item();
    return cspm_pkg::in_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
  endfunction

  function automatic cspm_pkg::in_t mk_load(int sel, int r, int col,
                                            logic signed [31:0] v);
    cspm_pkg::in_t c;
    c = rand_item();
    c.action = cspm_pkg::ACT_LOAD;
    c.factor_sel = 2'(sel);
    c.row = 10'(r);
    c.column = 4'(col);
    c.value = v;
    return c;
  endfunction

  // coordinates of factor-read modes come from preloaded rows; target is free
  function automatic cspm_pkg::in_t mk_nz(logic signed [31:0] v);
    cspm_pkg::in_t c;
    int co[4];
    c = rand_item();
    c.action = cspm_pkg::ACT_NZ;
    c.value = v;
    for (int m = 0; m < 4; m++) begin
      co[m] = hot_rows[$urandom_range(0, 3)];
      if (m == sb.tgt && $urandom_range(0, 3) == 0) co[m] = $urandom_range(0, NROWS - 1);
      if (m == 3 && sb.modes < 4 && $urandom_range(0, 1)) co[m] = $urandom_range(0, NROWS - 1);
    end
    c.idx_first = 10'(co[0]);
    c.idx_second = 10'(co[1]);
    c.idx_third = 10'(co[2]);
    c.idx_fourth = 10'(co[3]);
    if (sb.tgt < 4) touched.push_back(co[sb.tgt]);
    return c;
  endfunction

  function automatic cspm_pkg::in_t mk_read(int r, int col);
    cspm_pkg::in_t c;
    c = rand_item();
    c.action = cspm_pkg::ACT_READ;
    c.row = 10'(r);
    c.column = 4'(col);
    return c;
  endfunction

  function automatic cspm_pkg::in_t mk_clear();
    cspm_pkg::in_t c;
    c = rand_item();
    c.action = cspm_pkg::ACT_CLEAR;
    return c;
  endfunction

  task automatic run_random(int n);
    int r;
    cspm_pkg::in_t c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 199);
      if (r < 40) begin
        c = mk_load($urandom_range(0, 3),
                    $urandom_range(0, 4) == 0 ? $urandom_range(0, NROWS - 1)
                                              : hot_rows[$urandom_range(0, 3)],
                    $urandom_range(0, NRANK - 1), rand_q());
      end else if (r < 120) begin
        c = mk_nz(rand_q());
      end else if (r < 198) begin
        if (touched.size() != 0 && $urandom_range(0, 3) != 0)
          c = mk_read(touched[$urandom_range(0, touched.size() - 1)],
                      $urandom_range(0, NRANK - 1));
        else
          c = mk_read($urandom_range(0, NROWS - 1), $urandom_range(0, NRANK - 1));
      end else begin
        c = mk_clear();
      end
      issue(c);
    end
  endtask

  initial begin
    int tgts[8] = '{0, 2, 3, 1, 3, 0, 2, 1};
    int mcs[8]  = '{3, 3, 4, 4, 3, 7, 0, 4};
    repeat (12) @(negedge clk);
    rst = 0;

    // preload every factor row that a nonzero may read
    for (int m = 0; m < 4; m++)
      foreach (hot_rows[j])
        for (int k = 0; k < NRANK; k++)
          issue(mk_load(m, hot_rows[j], k, rand_q()));

    // directed: extremes of value and coordinates, every action
    issue(mk_load(0, 1023, 15, 32'sh7fffffff));
    issue(mk_load(1, 1023, 15, 32'sh80000000));
    issue(mk_load(2, 1023, 15, 32'sh7fffffff));
    issue(mk_nz(32'sh7fffffff));
    issue(mk_nz(32'sh80000000));
    issue(mk_nz(32'sh0));
    issue(mk_nz(32'sh10000));
    issue(mk_read(1023, 15));
    issue(mk_read(0, 0));
    issue(mk_clear());
    issue(mk_read(1023, 15));
    foreach (touched[j]) if (j < 6) issue(mk_read(touched[j], $urandom_range(0, 15)));

    foreach (tgts[p]) begin
      wait_idle();
      set_reg(cspm_pkg::REG_TARGET, 3'(tgts[p]));
      set_reg(cspm_pkg::REG_MODES, 3'(mcs[p]));
      touched.delete();
      if (p == 7) quiet = 1;
      run_random(p == 7 ? 120 : 80);
    end
    wait_idle();
    set_reg(cspm_pkg::REG_TARGET, 3'd7);
    run_random(100);

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
